FILE: sv/mla_pkg.sv
// Shared constants, types and control structs for the maxima layer assigner.
package mla_pkg;

  localparam int MAX_LAYERS = 64;
  localparam int COORD_BITS = 16;
  localparam int LAYER_BITS = 7;
  localparam int IDX_BITS   = $clog2(MAX_LAYERS);
  localparam int CNT_BITS   = $clog2(MAX_LAYERS + 1);

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [IDX_BITS-1:0]   idx_t;
  typedef logic [CNT_BITS-1:0]   cnt_t;
  typedef logic [LAYER_BITS-1:0] layer_t;

  // Outcome of the parallel tail search.
  typedef struct packed {
    logic found;
    idx_t index;
  } search_t;

  // Update of one layer tail.
  typedef struct packed {
    logic   en;
    idx_t   addr;
    coord_t data;
  } tail_write_t;

endpackage

FILE: sv/mla_if.sv
// Handshake interfaces for the point input channel and the result channel.
interface mla_point_if;
  import mla_pkg::*;
  logic   valid;
  logic   ready;
  coord_t point_x;
  coord_t point_y;
  logic   start_set;

  modport source (output valid, output point_x, output point_y, output start_set,
                  input ready);
  modport sink (input valid, input point_x, input point_y, input start_set,
                output ready);
endinterface

interface mla_result_if;
  import mla_pkg::*;
  logic   valid;
  logic   ready;
  coord_t out_x;
  coord_t out_y;
  layer_t layer_number;

  modport source (output valid, output out_x, output out_y, output layer_number,
                  input ready);
  modport sink (input valid, input out_x, input out_y, input layer_number,
                output ready);
endinterface

FILE: sv/mla_tail_store.sv
// Layer tail registers with one compare lane per layer and a priority encoder.
module mla_tail_store (
  input  logic                 clk,
  input  mla_pkg::coord_t      probe_y,
  input  mla_pkg::cnt_t        open_count,
  input  mla_pkg::tail_write_t wr,
  output mla_pkg::search_t     search
);
  import mla_pkg::*;

  coord_t                tail [MAX_LAYERS];
  logic [MAX_LAYERS-1:0] below;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      tail[wr.addr] <= wr.data;
    end
  end

  // One lane per layer: only open layers take part.
  always_comb begin
    for (int i = 0; i < MAX_LAYERS; i++) begin
      below[i] = (cnt_t'(i) < open_count) && (tail[i] < probe_y);
    end
  end

  // Lowest-numbered qualifying layer wins.
  always_comb begin
    search = '0;
    for (int i = MAX_LAYERS - 1; i >= 0; i--) begin
      if (below[i]) begin
        search.found = 1'b1;
        search.index = idx_t'(i);
      end
    end
  end

endmodule

FILE: sv/maxima_layer_assigner_top.sv
// Top level of the maxima layer assigner: input stage, layer bookkeeping, result register.
//
//   channel   dir  payload                          transfer when
//   point     in   point_x, point_y, start_set      point.valid && point.ready
//   result    out  out_x, out_y, layer_number       result.valid && result.ready
//
// One point per cycle while the result register is not stalled. A point is
// registered on transfer, classified in the input stage against the layer
// tails, and lands in the result register when that register can take it. The
// cycle is set by the 64 parallel tail compares and the priority encoder.
// Reset clears the layer count, the previous point and both valid flags; the
// tails need no clearing since only open layers are compared. A stalled result
// register holds the classify stage, but a duplicate point still retires there.
module maxima_layer_assigner_top (
  input logic          clk,
  input logic          rst,
  mla_point_if.sink    point,
  mla_result_if.source result
);
  import mla_pkg::*;

  // Input stage
  logic   stage_valid;
  coord_t stage_x;
  coord_t stage_y;
  logic   stage_start;

  // Layer bookkeeping
  cnt_t   layers_open;
  cnt_t   layers_open_next;
  coord_t previous_x;
  coord_t previous_y;
  logic   previous_valid;

  // Result register
  logic   res_valid;
  coord_t res_x;
  coord_t res_y;
  layer_t res_layer;

  logic        prev_live;
  cnt_t        open_live;
  logic        dup;
  logic        can_load;
  logic        advance;
  logic        emit;
  cnt_t        layer_full;
  search_t     search;
  tail_write_t wr;

  mla_tail_store u_tail_store (
    .clk        (clk),
    .probe_y    (stage_y),
    .open_count (open_live),
    .wr         (wr),
    .search     (search)
  );

  // A start flag wipes the store before this point is looked at.
  assign prev_live = previous_valid && !stage_start;
  assign open_live = stage_start ? '0 : layers_open;
  assign dup       = prev_live && (stage_x == previous_x) && (stage_y == previous_y);

  // Advance the stage when the result register can take the point,
  // or drop a duplicate right away since it yields no result.
  assign can_load    = !res_valid || result.ready;
  assign advance     = stage_valid && (dup || can_load);
  assign emit        = advance && !dup;
  assign point.ready = !stage_valid || advance;

  // Join the first qualifying layer, else open a new one, else report store full.
  always_comb begin
    wr               = '0;
    wr.data          = stage_y;
    layer_full       = '0;
    layers_open_next = open_live;
    if (search.found) begin
      wr.en      = emit;
      wr.addr    = search.index;
      layer_full = cnt_t'(search.index) + cnt_t'(1);
    end else if (open_live < cnt_t'(MAX_LAYERS)) begin
      wr.en            = emit;
      wr.addr          = idx_t'(open_live);
      layer_full       = open_live + cnt_t'(1);
      layers_open_next = open_live + cnt_t'(1);
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid    <= 1'b0;
      res_valid      <= 1'b0;
      layers_open    <= '0;
      previous_valid <= 1'b0;
      previous_x     <= '0;
      previous_y     <= '0;
    end else begin
      if (point.ready) begin
        stage_valid <= point.valid;
      end
      if (emit) begin
        layers_open    <= layers_open_next;
        previous_x     <= stage_x;
        previous_y     <= stage_y;
        previous_valid <= 1'b1;
      end
      if (emit) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (point.valid && point.ready) begin
      stage_x     <= point.point_x;
      stage_y     <= point.point_y;
      stage_start <= point.start_set;
    end
    if (emit) begin
      res_x     <= stage_x;
      res_y     <= stage_y;
      res_layer <= layer_t'(layer_full);
    end
  end

  assign result.valid        = res_valid;
  assign result.out_x        = res_x;
  assign result.out_y        = res_y;
  assign result.layer_number = res_layer;

  a_open_bounded: assert property (@(posedge clk) disable iff (rst)
    layers_open <= cnt_t'(MAX_LAYERS))
    else $error("layer count beyond store size");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> point.ready)
    else $error("input stalled with empty result register");

  a_open_step: assert property (@(posedge clk) disable iff (rst)
    (layers_open != $past(layers_open)) |->
      ((layers_open == $past(layers_open) + cnt_t'(1)) || (layers_open == cnt_t'(1))))
    else $error("layer count moved by more than one");

endmodule
